// File: hdl/sorted_array_table_top_defines.svh
// Assertion macros for the sorted table block.
// Included by the modules that carry concurrent checks; needs nothing else.
`ifndef SORTED_ARRAY_TABLE_TOP_DEFINES_SVH
`define SORTED_ARRAY_TABLE_TOP_DEFINES_SVH

// same-cycle implication
`define SAT_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SAT_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/sat_pkg.sv
// Shared types and codes for the sorted table block.
// No dependencies.
`default_nettype none

package sat_pkg;

   localparam int CAP_W   = 9;
   localparam int CMD_W   = 2;
   localparam int STAT_W  = 2;
   localparam int DATA_W  = 32;
   localparam int POS_W   = 8;
   localparam int COUNT_W = 9;

   localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

   localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
   localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
   localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [DATA_W-1:0] key;
      logic [POS_W-1:0]  position;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0]  read_data;
      logic [STAT_W-1:0]  status;
      logic [COUNT_W-1:0] count;
   } rsp_type;

endpackage

`default_nettype wire

// File: hdl/sorted_array_table_top.sv
// Every command ends in S_FIN, which returns the response; full or range errors and the
// spare command go straight there, as does an insert into an empty table after its one write.
// Throughput: one command at a time; insert and remove pass once through the table
// using one RAM read and one RAM write per cycle.
// Reset (synchronous): count cleared, capacity set to 256; table contents untouched.
`default_nettype none
`include "sorted_array_table_top_defines.svh"

module sorted_array_table_top
   import sat_pkg::*;
#(
   parameter int DEPTH    = 256,
   parameter int KEY_BITS = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire req_type          req_beat,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output rsp_type               rsp_beat,
   input  wire logic             csr_wr_en,
   input  wire logic [CAP_W-1:0] csr_wr_data
);

   localparam int AW      = $clog2(DEPTH);
   localparam int CNT_MAX = (DEPTH < 511) ? DEPTH : 511;
   localparam int CNT_W   = $clog2(CNT_MAX + 1);
   localparam int CMP_W   = $clog2(DEPTH + 1) + CAP_W;

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_INS  = 6'b000010,
      S_PUT  = 6'b000100,
      S_RD   = 6'b001000,
      S_DN   = 6'b010000,
      S_FIN  = 6'b100000
   } state_type;

   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [CAP_W-1:0]    cap_ff;
   logic [CMD_W-1:0]    cmd_ff, cmd_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [AW-1:0]       idx_ff, idx_in;
   logic [KEY_BITS-1:0] data_ff, data_in;
   logic [STAT_W-1:0]   status_ff, status_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_beat_ff, rsp_beat_in;

   logic                rd_en, wr_en;
   logic [AW-1:0]       rd_addr, wr_addr;
   logic [KEY_BITS-1:0] wr_data, rd_data;
   logic                full, out_of_range, last_idx;

   sat_ram #(
      .WIDTH (KEY_BITS),
      .DEPTH (DEPTH)
   ) u_entries (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign full = (CMP_W'(cnt_ff) >= CMP_W'(cap_ff)) || (CMP_W'(cnt_ff) >= CMP_W'(DEPTH));
   assign out_of_range = CMP_W'(req_beat.position) >= CMP_W'(cnt_ff);
   assign last_idx = (CMP_W'(idx_ff) + CMP_W'(1)) == CMP_W'(cnt_ff);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      cmd_in       = cmd_ff;
      key_in       = key_ff;
      idx_in       = idx_ff;
      data_in      = data_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_beat_in  = rsp_beat_ff;
      rd_en        = 1'b0;
      rd_addr      = idx_ff;
      wr_en        = 1'b0;
      wr_addr      = idx_ff;
      wr_data      = key_ff;
      req_stall    = (state_ff != S_IDLE);

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in    = req_beat.command;
               key_in    = KEY_BITS'(req_beat.key);
               data_in   = '0;
               status_in = STAT_DONE;
               state_in  = S_FIN;
               case (req_beat.command)
                  CMD_INSERT: begin
                     if (full) begin
                        status_in = STAT_FULL;
                     end else if (cnt_ff == '0) begin
                        wr_en   = 1'b1;
                        wr_addr = '0;
                        wr_data = KEY_BITS'(req_beat.key);
                        cnt_in  = cnt_ff + 1'b1;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = AW'(cnt_ff - 1'b1);
                        idx_in   = AW'(cnt_ff - 1'b1);
                        state_in = S_INS;
                     end
                  end
                  CMD_LOOKUP, CMD_REMOVE: begin
                     if (out_of_range) begin
                        status_in = STAT_RANGE;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = AW'(req_beat.position);
                        idx_in   = AW'(req_beat.position);
                        state_in = S_RD;
                     end
                  end
                  default: begin
                     state_in = S_FIN;
                  end
               endcase
            end
         end
         S_INS: begin
            // scan down from the top, moving entries not below the key up one slot
            wr_en   = 1'b1;
            wr_addr = idx_ff + 1'b1;
            if (!(rd_data < key_ff)) begin
               wr_data = rd_data;
               if (idx_ff == '0) begin
                  state_in = S_PUT;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = idx_ff - 1'b1;
                  idx_in  = idx_ff - 1'b1;
               end
            end else begin
               wr_data  = key_ff;
               cnt_in   = cnt_ff + 1'b1;
               state_in = S_FIN;
            end
         end
         S_PUT: begin
            wr_en    = 1'b1;
            wr_addr  = '0;
            wr_data  = key_ff;
            cnt_in   = cnt_ff + 1'b1;
            state_in = S_FIN;
         end
         S_RD: begin
            data_in = rd_data;
            if (cmd_ff == CMD_LOOKUP) begin
               state_in = S_FIN;
            end else if (last_idx) begin
               cnt_in   = cnt_ff - 1'b1;
               state_in = S_FIN;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = idx_ff + 1'b1;
               idx_in   = idx_ff + 1'b1;
               state_in = S_DN;
            end
         end
         S_DN: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff - 1'b1;
            wr_data = rd_data;
            if (last_idx) begin
               cnt_in   = cnt_ff - 1'b1;
               state_in = S_FIN;
            end else begin
               rd_en   = 1'b1;
               rd_addr = idx_ff + 1'b1;
               idx_in  = idx_ff + 1'b1;
            end
         end
         S_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in          = 1'b1;
               rsp_beat_in.read_data = DATA_W'(data_ff);
               rsp_beat_in.status    = status_ff;
               rsp_beat_in.count     = COUNT_W'(cnt_ff);
               state_in              = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      key_ff      <= key_in;
      idx_ff      <= idx_in;
      data_ff     <= data_in;
      status_ff   <= status_in;
      rsp_beat_ff <= rsp_beat_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_beat  = rsp_beat_ff;

   `SAT_ASSERT_NXT(a_accept_leaves_idle, clock, reset,
      req_valid && !req_stall, state_ff != S_IDLE,
      "beat accepted but block stayed idle")
   `SAT_ASSERT_IMP(a_no_same_addr, clock, reset,
      rd_en && wr_en, rd_addr != wr_addr,
      "RAM read and write hit the same entry")
   `SAT_ASSERT_NXT(a_count_step, clock, reset, 1'b1,
      (cnt_ff == $past(cnt_ff))
      || ((CNT_W + 1)'(cnt_ff) == (CNT_W + 1)'($past(cnt_ff)) + 1'b1)
      || ((CNT_W + 1)'(cnt_ff) + 1'b1 == (CNT_W + 1)'($past(cnt_ff))),
      "count moved by more than one")
   `SAT_ASSERT_IMP(a_err_data_zero, clock, reset,
      rsp_valid_ff && (rsp_beat_ff.status != STAT_DONE), rsp_beat_ff.read_data == '0,
      "error result with nonzero data")

endmodule

`default_nettype wire

// File: hdl/sat_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module sat_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire
